>>> src/ubxr_pkg.sv
// Package with the shared types and constants of the frame receiver.
`default_nettype none

package ubxr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

  localparam logic [7:0] SYNC_FIRST_RST = 8'd181;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CHK_A   = 9'b010000000,
    PH_CHK_B   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  msg_class;
    logic [7:0]  message_id;
    logic [15:0] payload_length;
    logic        checksum_ok;
  } result_t;

endpackage

`default_nettype wire

>>> src/ubxr_front.sv
// Frame parser that takes received bytes, tracks the checksum and issues result entries.
`default_nettype none

module ubxr_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic [7:0]                     in_rx_byte,
  input  wire logic                           queue_full,
  output logic                                in_stall,
  input  wire logic                           cfg_valid,
  input  wire logic [ubxr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data,
  output logic                                push,
  output ubxr_pkg::result_t                   push_entry
);

  ubxr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  sync_first_r, sync_second_r;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  chk_a_r, chk_a_nxt;
  logic        accept;
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] count_inc;
  logic [15:0] length_full;

  assign in_stall = queue_full;
  assign accept = in_valid && !queue_full;
  assign add_a = sum_a_r + in_rx_byte;
  assign add_b = sum_b_r + add_a;
  assign count_inc = count_r + 16'd1;
  assign length_full = {in_rx_byte, length_r[7:0]};

  always_comb begin
    phase_nxt = phase_r;
    class_nxt = class_r;
    id_nxt = id_r;
    length_nxt = length_r;
    count_nxt = count_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    chk_a_nxt = chk_a_r;
    push = 1'b0;
    push_entry.kind = ubxr_pkg::KIND_PAYLOAD;
    push_entry.data_byte = in_rx_byte;
    push_entry.byte_index = count_r;
    push_entry.msg_class = class_r;
    push_entry.message_id = id_r;
    push_entry.payload_length = length_r;
    push_entry.checksum_ok = 1'b0;
    if (accept) begin
      case (phase_r)
        ubxr_pkg::PH_SYNC2: begin
          phase_nxt = (in_rx_byte == sync_second_r) ? ubxr_pkg::PH_CLASS : ubxr_pkg::PH_HUNT;
        end
        ubxr_pkg::PH_CLASS: begin
          class_nxt = in_rx_byte;
          sum_a_nxt = in_rx_byte;
          sum_b_nxt = in_rx_byte;
          phase_nxt = ubxr_pkg::PH_ID;
        end
        ubxr_pkg::PH_ID: begin
          id_nxt = in_rx_byte;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = ubxr_pkg::PH_LEN_LO;
        end
        ubxr_pkg::PH_LEN_LO: begin
          length_nxt = {8'd0, in_rx_byte};
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = ubxr_pkg::PH_LEN_HI;
        end
        ubxr_pkg::PH_LEN_HI: begin
          length_nxt = length_full;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          count_nxt = 16'd0;
          phase_nxt = (length_full != 16'd0) ? ubxr_pkg::PH_PAYLOAD : ubxr_pkg::PH_CHK_A;
        end
        ubxr_pkg::PH_PAYLOAD: begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          push = 1'b1;
          count_nxt = count_inc;
          if (count_inc == length_r) begin
            phase_nxt = ubxr_pkg::PH_CHK_A;
          end
        end
        ubxr_pkg::PH_CHK_A: begin
          chk_a_nxt = in_rx_byte;
          phase_nxt = ubxr_pkg::PH_CHK_B;
        end
        ubxr_pkg::PH_CHK_B: begin
          push = 1'b1;
          push_entry.kind = ubxr_pkg::KIND_END;
          push_entry.data_byte = 8'd0;
          push_entry.byte_index = 16'd0;
          push_entry.checksum_ok = (chk_a_r == sum_a_r) && (in_rx_byte == sum_b_r);
          phase_nxt = ubxr_pkg::PH_HUNT;
        end
        default: begin
          phase_nxt = (in_rx_byte == sync_first_r) ? ubxr_pkg::PH_SYNC2 : ubxr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ubxr_pkg::PH_HUNT;
      class_r <= 8'd0;
      id_r <= 8'd0;
      length_r <= 16'd0;
      count_r <= 16'd0;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
      chk_a_r <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      class_r <= class_nxt;
      id_r <= id_nxt;
      length_r <= length_nxt;
      count_r <= count_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      chk_a_r <= chk_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r <= ubxr_pkg::SYNC_FIRST_RST;
      sync_second_r <= ubxr_pkg::SYNC_SECOND_RST;
    end else if (cfg_valid) begin
      if (cfg_index == ubxr_pkg::CFG_SYNC_FIRST) begin
        sync_first_r <= cfg_data;
      end else if (cfg_index == ubxr_pkg::CFG_SYNC_SECOND) begin
        sync_second_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/ubxr_queue.sv
// Short first-in first-out queue of result entries between the parser and the output stage.
`default_nettype none

module ubxr_queue #(
  parameter int unsigned DEPTH = ubxr_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  ubxr_pkg::result_t      push_entry,
  input  wire logic              pop,
  output ubxr_pkg::result_t      head_entry,
  output logic                   full,
  output logic                   not_empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ubxr_pkg::result_t store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign head_entry = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

>>> src/ubxr_out.sv
// Output stage that takes entries from the queue and holds each result until it is taken.
`default_nettype none

module ubxr_out (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  ubxr_pkg::result_t  head_entry,
  output logic               pop,
  input  wire logic          out_stall,
  output logic               out_valid,
  output ubxr_pkg::result_t  out_entry
);

  logic              valid_r, valid_nxt;
  ubxr_pkg::result_t entry_r;

  assign pop = head_valid && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_entry = entry_r;

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      entry_r <= head_entry;
    end
  end

endmodule

`default_nettype wire

>>> src/ubx_frame_receiver_core.sv
// Top level of the frame receiver: parser, result queue and output stage.
// Throughput is one byte per cycle while the result queue is not full; in_stall rises
// only while the result queue is full. A result passes through the result queue and the output
// stage register before it shows on the outputs, and its transaction comes later when stalled.
// Reset is synchronous and active low: the parser hunts for the first sync byte, the sync
// values return to 181 and 98, and the queue and output stage empty.
`default_nettype none

module ubx_frame_receiver_core #(
  parameter int unsigned QUEUE_DEPTH = ubxr_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_kind,
  output logic [7:0]                          out_data_byte,
  output logic [15:0]                         out_byte_index,
  output logic [7:0]                          out_msg_class,
  output logic [7:0]                          out_message_id,
  output logic [15:0]                         out_payload_length,
  output logic                                out_checksum_ok,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ubxr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);

  logic              queue_full;
  logic              queue_not_empty;
  logic              push;
  logic              pop;
  ubxr_pkg::result_t push_entry;
  ubxr_pkg::result_t head_entry;
  ubxr_pkg::result_t out_entry;

  assign cfg_ready = 1'b1;

  ubxr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .queue_full (queue_full),
    .in_stall   (in_stall),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_entry (push_entry)
  );

  ubxr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .full       (queue_full),
    .not_empty  (queue_not_empty)
  );

  ubxr_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (queue_not_empty),
    .head_entry (head_entry),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_entry  (out_entry)
  );

  assign out_kind = out_entry.kind;
  assign out_data_byte = out_entry.data_byte;
  assign out_byte_index = out_entry.byte_index;
  assign out_msg_class = out_entry.msg_class;
  assign out_message_id = out_entry.message_id;
  assign out_payload_length = out_entry.payload_length;
  assign out_checksum_ok = out_entry.checksum_ok;

endmodule

`default_nettype wire

>>> verif/ubxr_frame_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the frame receiver's results from observed transactions and compares them.
module ubxr_frame_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_kind,
  input  logic [7:0]                     out_data_byte,
  input  logic [15:0]                    out_byte_index,
  input  logic [7:0]                     out_msg_class,
  input  logic [7:0]                     out_message_id,
  input  logic [15:0]                    out_payload_length,
  input  logic                           out_checksum_ok,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ubxr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int unsigned                    mismatch_count,
  output int unsigned                    pending_count,
  output int unsigned                    verdict_count,
  output int unsigned                    good_verdict_count,
  output int unsigned                    payload_result_count
);

  ubxr_pkg::phase_t  rx_phase;
  logic [7:0]        sync_first_val;
  logic [7:0]        sync_second_val;
  logic [7:0]        hdr_class;
  logic [7:0]        hdr_id;
  logic [15:0]       hdr_length;
  logic [15:0]       payload_index;
  logic [7:0]        fletcher_a;
  logic [7:0]        fletcher_b;
  logic [7:0]        rx_check_a;
  ubxr_pkg::result_t frame_results[$];
  ubxr_pkg::result_t seen;
  ubxr_pkg::result_t want;
  int unsigned       mismatches;
  int unsigned       verdicts;
  int unsigned       good_verdicts;
  int unsigned       payload_results;

  function automatic void fletcher_add(input logic [7:0] b);
    fletcher_a = fletcher_a + b;
    fletcher_b = fletcher_b + fletcher_a;
  endfunction

  function automatic void queue_result(input logic k, input logic [7:0] d,
                                       input logic [15:0] idx, input logic ok);
    ubxr_pkg::result_t r;
    r.kind = k;
    r.data_byte = d;
    r.byte_index = idx;
    r.msg_class = hdr_class;
    r.message_id = hdr_id;
    r.payload_length = hdr_length;
    r.checksum_ok = ok;
    frame_results.push_back(r);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    case (rx_phase)
      ubxr_pkg::PH_SYNC2: begin
        rx_phase = (b == sync_second_val) ? ubxr_pkg::PH_CLASS : ubxr_pkg::PH_HUNT;
      end
      ubxr_pkg::PH_CLASS: begin
        hdr_class = b;
        fletcher_a = 8'd0;
        fletcher_b = 8'd0;
        fletcher_add(b);
        rx_phase = ubxr_pkg::PH_ID;
      end
      ubxr_pkg::PH_ID: begin
        hdr_id = b;
        fletcher_add(b);
        rx_phase = ubxr_pkg::PH_LEN_LO;
      end
      ubxr_pkg::PH_LEN_LO: begin
        hdr_length = {8'd0, b};
        fletcher_add(b);
        rx_phase = ubxr_pkg::PH_LEN_HI;
      end
      ubxr_pkg::PH_LEN_HI: begin
        hdr_length[15:8] = b;
        fletcher_add(b);
        payload_index = 16'd0;
        rx_phase = (hdr_length != 16'd0) ? ubxr_pkg::PH_PAYLOAD : ubxr_pkg::PH_CHK_A;
      end
      ubxr_pkg::PH_PAYLOAD: begin
        fletcher_add(b);
        queue_result(ubxr_pkg::KIND_PAYLOAD, b, payload_index, 1'b0);
        payload_index = payload_index + 16'd1;
        if (payload_index == hdr_length) rx_phase = ubxr_pkg::PH_CHK_A;
      end
      ubxr_pkg::PH_CHK_A: begin
        rx_check_a = b;
        rx_phase = ubxr_pkg::PH_CHK_B;
      end
      ubxr_pkg::PH_CHK_B: begin
        queue_result(ubxr_pkg::KIND_END, 8'd0, 16'd0,
                     (rx_check_a == fletcher_a) && (b == fletcher_b));
        rx_phase = ubxr_pkg::PH_HUNT;
      end
      default: begin
        rx_phase = (b == sync_first_val) ? ubxr_pkg::PH_SYNC2 : ubxr_pkg::PH_HUNT;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_phase = ubxr_pkg::PH_HUNT;
      sync_first_val = ubxr_pkg::SYNC_FIRST_RST;
      sync_second_val = ubxr_pkg::SYNC_SECOND_RST;
      hdr_class = 8'd0;
      hdr_id = 8'd0;
      hdr_length = 16'd0;
      payload_index = 16'd0;
      fletcher_a = 8'd0;
      fletcher_b = 8'd0;
      rx_check_a = 8'd0;
      frame_results.delete();
      mismatches = 0;
      verdicts = 0;
      good_verdicts = 0;
      payload_results = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.kind = out_kind;
        seen.data_byte = out_data_byte;
        seen.byte_index = out_byte_index;
        seen.msg_class = out_msg_class;
        seen.message_id = out_message_id;
        seen.payload_length = out_payload_length;
        seen.checksum_ok = out_checksum_ok;
        if (frame_results.size() == 0) begin
          $error("Result transaction with nothing expected: kind %0d data %0d index %0d",
                 seen.kind, seen.data_byte, seen.byte_index);
          mismatches++;
        end else begin
          want = frame_results.pop_front();
          check_field("kind", 16'(want.kind), 16'(seen.kind));
          check_field("data_byte", 16'(want.data_byte), 16'(seen.data_byte));
          check_field("byte_index", want.byte_index, seen.byte_index);
          check_field("msg_class", 16'(want.msg_class), 16'(seen.msg_class));
          check_field("message_id", 16'(want.message_id), 16'(seen.message_id));
          check_field("payload_length", want.payload_length, seen.payload_length);
          check_field("checksum_ok", 16'(want.checksum_ok), 16'(seen.checksum_ok));
          if (want.kind == ubxr_pkg::KIND_END) begin
            verdicts++;
            if (want.checksum_ok) good_verdicts++;
          end else begin
            payload_results++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ubxr_pkg::CFG_SYNC_FIRST) sync_first_val = cfg_data;
        else if (cfg_index == ubxr_pkg::CFG_SYNC_SECOND) sync_second_val = cfg_data;
      end
      if (in_valid && !in_stall) parse_rx_byte(in_rx_byte);
    end
    mismatch_count <= mismatches;
    pending_count <= frame_results.size();
    verdict_count <= verdicts;
    good_verdict_count <= good_verdicts;
    payload_result_count <= payload_results;
  end

endmodule

>>> verif/ubx_frame_receiver_core_test.sv
`timescale 1ns / 100ps
// Testbench top for the frame receiver: stimulus, idling control and the final verdict.
module ubx_frame_receiver_core_test;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_BYTES = 90;
  localparam logic [15:0] LONGEST_LENGTH = 16'd258;
  localparam logic [ubxr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [ubxr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int unsigned {CHK_INTACT, CHK_BREAK_A, CHK_BREAK_B} damage_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_rx_byte = 8'd0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_kind;
  logic [7:0]                     out_data_byte;
  logic [15:0]                    out_byte_index;
  logic [7:0]                     out_msg_class;
  logic [7:0]                     out_message_id;
  logic [15:0]                    out_payload_length;
  logic                           out_checksum_ok;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ubxr_pkg::CFG_IDX_W-1:0] cfg_index = ubxr_pkg::CFG_SYNC_FIRST;
  logic [7:0]                     cfg_data = 8'd0;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned verdict_count;
  int unsigned good_verdict_count;
  int unsigned payload_result_count;

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  sync_a = ubxr_pkg::SYNC_FIRST_RST;
  logic [7:0]  sync_b = ubxr_pkg::SYNC_SECOND_RST;
  logic [7:0]  tx_sum_a;
  logic [7:0]  tx_sum_b;

  ubx_frame_receiver_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_data_byte(out_data_byte),
    .out_byte_index(out_byte_index),
    .out_msg_class(out_msg_class),
    .out_message_id(out_message_id),
    .out_payload_length(out_payload_length),
    .out_checksum_ok(out_checksum_ok),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  ubxr_frame_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_data_byte(out_data_byte),
    .out_byte_index(out_byte_index),
    .out_msg_class(out_msg_class),
    .out_message_id(out_message_id),
    .out_payload_length(out_payload_length),
    .out_checksum_ok(out_checksum_ok),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count),
    .pending_count(pending_count),
    .verdict_count(verdict_count),
    .good_verdict_count(good_verdict_count),
    .payload_result_count(payload_result_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("No transaction for %0d cycles, %0d results still expected.",
               QUIET_LIMIT, pending_count);
      $display("ubx_frame_receiver_core_test: FAIL");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic push_summed(input logic [7:0] b);
    push_byte(b);
    tx_sum_a = tx_sum_a + b;
    tx_sum_b = tx_sum_b + tx_sum_a;
  endtask

  task automatic write_reg(input logic [ubxr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_sync(input logic [7:0] first_val, input logic [7:0] second_val);
    write_reg(ubxr_pkg::CFG_SYNC_FIRST, first_val);
    write_reg(ubxr_pkg::CFG_SYNC_SECOND, second_val);
    sync_a = first_val;
    sync_b = second_val;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] mid,
                            input logic [15:0] len, input damage_t damage);
    int unsigned k;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    tx_sum_a = 8'd0;
    tx_sum_b = 8'd0;
    push_byte(sync_a);
    push_byte(sync_b);
    push_summed(cls);
    push_summed(mid);
    push_summed(len[7:0]);
    push_summed(len[15:8]);
    for (k = 0; k < len; k++) push_summed(8'($urandom_range(255)));
    ck_a = tx_sum_a;
    ck_b = tx_sum_b;
    if (damage == CHK_BREAK_A) ck_a = ck_a ^ (8'd1 << $urandom_range(7));
    if (damage == CHK_BREAK_B) ck_b = ck_b ^ (8'd1 << $urandom_range(7));
    push_byte(ck_a);
    push_byte(ck_b);
  endtask

  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned noise_n;
    logic [15:0] len;
    logic [7:0]  b;
    damage_t     damage;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        if ($urandom_range(99) < 4) len = 16'($urandom_range(300, 250));
        else len = 16'($urandom_range(12));
        pick = $urandom_range(99);
        if (pick < 8) damage = CHK_BREAK_A;
        else if (pick < 16) damage = CHK_BREAK_B;
        else damage = CHK_INTACT;
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, damage);
      end else if (pick < 88) begin
        push_byte(sync_a);
        if (sync_a != sync_b && $urandom_range(1) == 1) b = sync_a;
        else b = 8'($urandom_range(255));
        if (b == sync_b) b = ~sync_b;
        push_byte(b);
      end else begin
        noise_n = $urandom_range(4, 1);
        repeat (noise_n) begin
          b = 8'($urandom_range(255));
          if (b == sync_a) b = ~b;
          push_byte(b);
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    // Writes to unused indexes must leave both sync values alone.
    write_reg(CFG_SPARE_LO, 8'($urandom_range(255)));
    write_reg(CFG_SPARE_HI, 8'($urandom_range(255)));

    push_byte(8'h00);
    push_byte(8'hFF);
    // A first sync byte in place of the second one is dropped, and so is what follows.
    push_byte(sync_a);
    push_byte(sync_a);
    push_byte(sync_b);
    send_frame(8'hFF, 8'h00, 16'd0, CHK_INTACT);
    send_frame(8'h00, 8'hFF, 16'd1, CHK_BREAK_B);
    send_frame(8'hA5, 8'h5A, LONGEST_LENGTH, CHK_INTACT);
    random_traffic(PHASE_BYTES);
    drain_and_settle();

    set_sync(8'h00, 8'hFF);
    in_idle_pct = 50;
    out_stall_pct = 0;
    random_traffic(PHASE_BYTES);
    drain_and_settle();

    set_sync(8'hFF, 8'h00);
    in_idle_pct = 0;
    out_stall_pct = 50;
    random_traffic(PHASE_BYTES);
    drain_and_settle();

    sync_a = 8'($urandom_range(255));
    if ($urandom_range(99) < 30) sync_b = sync_a;
    else sync_b = 8'($urandom_range(255));
    set_sync(sync_a, sync_b);
    in_idle_pct = 35;
    out_stall_pct = 35;
    random_traffic(PHASE_BYTES);
    drain_and_settle();

    $display("Sent %0d bytes; checked %0d payload results and %0d frame verdicts, %0d good.",
             bytes_sent, payload_result_count, verdict_count, good_verdict_count);
    $display("Four sync settings and four idling mixes, with one frame using both length bytes.");
    if (mismatch_count == 0) begin
      $display("ubx_frame_receiver_core_test: PASS");
    end else begin
      $display("ubx_frame_receiver_core_test: FAIL");
    end
    $finish;
  end

endmodule
